// ----- src/sal_pkg.sv -----
`timescale 1ns / 1ps

package sal_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_WAYS         = 4;
    localparam int DEF_MAX_SET_BITS = 11;
    localparam int DEF_LINE_BYTES   = 64;
    localparam int DEF_ADDR_BITS    = 48;

    // Fixed field widths.
    localparam int CNT_W     = 48;
    localparam int CFG_W     = 4;
    localparam int WAY_OUT_W = 2;

    localparam logic [CFG_W-1:0] SET_BITS_RESET = 4'd11;

    // Operation codes of the op field.
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

endpackage

// ----- src/set_assoc_lru_cache_model_unit.sv -----
`timescale 1ns / 1ps

// Tag-only model of a set-associative cache with true LRU replacement. Issue an
// item by raising start while busy is low; an access (op = 0) first reads the
// set's tag row and state row synchronously, then compares all ways, chooses
// the victim, writes the state row back, writes the tag row on a miss and
// updates the counters. The result appears, registered, with done high for
// exactly one cycle, and it must be taken then, since the receiver cannot stall
// the block. Busy stays high while an access is in flight, so at most one item
// is in the block and no two accesses to the same set ever overlap. A clear
// item (op = 1) returns its all-zero result in the cycle after it is accepted
// and then sweeps the set-state memory, one set per cycle, through all
// 2**MAX_SET_BITS sets (2048 at the defaults) with busy high; the same sweep
// runs right after reset. The set count register may be written through the
// cfg channel, which is always ready, whenever the block is idle.
module set_assoc_lru_cache_model_unit #(
    parameter int WAYS         = sal_pkg::DEF_WAYS,
    parameter int MAX_SET_BITS = sal_pkg::DEF_MAX_SET_BITS,
    parameter int LINE_BYTES   = sal_pkg::DEF_LINE_BYTES,
    parameter int ADDR_BITS    = sal_pkg::DEF_ADDR_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           op,
    input  logic [ADDR_BITS-1:0]           address,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sal_pkg::CFG_W-1:0]      cfg_data,
    output logic                           done,
    output logic                           hit,
    output logic [sal_pkg::WAY_OUT_W-1:0]  way_used,
    output logic [sal_pkg::CNT_W-1:0]      hit_total,
    output logic [sal_pkg::CNT_W-1:0]      miss_total,
    output logic [sal_pkg::CNT_W-1:0]      access_total
);

    import sal_pkg::*;

    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int TAG_W  = ADDR_BITS - OFF_W;
    localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_W  = RANK_W;
    localparam int SET_W  = MAX_SET_BITS;
    localparam int ST_W   = WAYS + WAYS * RANK_W;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  set_bits_reg;
    logic [SET_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [SET_W-1:0]  set_reg, set_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic              done_reg, done_next;
    logic              hit_reg, hit_next;
    logic [WAY_W-1:0]  way_reg, way_next;
    logic [CNT_W-1:0]  hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]  miss_cnt_reg, miss_cnt_next;
    logic [CNT_W-1:0]  acc_cnt_reg, acc_cnt_next;

    // Address split: the line address is the tag; the set index is its low bits
    // under a mask built from the (saturated) set count register.
    logic [TAG_W-1:0]       in_line;
    logic [TAG_W+SET_W-1:0] in_line_ext;
    logic [SET_W-1:0]       set_mask;
    logic [SET_W-1:0]       in_set;
    int                     set_bits_eff;

    assign in_line     = address[ADDR_BITS-1:OFF_W];
    assign in_line_ext = (TAG_W + SET_W)'(in_line);

    always_comb
    begin
        set_bits_eff = (int'(set_bits_reg) > MAX_SET_BITS) ? MAX_SET_BITS
                                                           : int'(set_bits_reg);
        for (int i = 0; i < SET_W; i++)
        begin
            set_mask[i] = (i < set_bits_eff);
        end
        in_set = in_line_ext[SET_W-1:0] & set_mask;
    end

    // Memory ports.
    logic                    rd_en;
    logic                    st_wr_en;
    logic [SET_W-1:0]        st_wr_addr;
    logic [ST_W-1:0]         st_wr_data;
    logic [ST_W-1:0]         st_rd_data;
    logic                    tag_wr_en;
    logic [WAYS*TAG_W-1:0]   tag_rd_data;

    // Lookup results.
    logic                    lk_hit;
    logic [WAY_W-1:0]        lk_way;
    logic [WAYS-1:0]         lk_valid;
    logic [WAYS*RANK_W-1:0]  lk_ranks;
    logic [WAYS*TAG_W-1:0]   lk_tags;
    logic [WAYS*RANK_W-1:0]  init_ranks;

    // The set-state row holds the valid bits in its low part and the recency
    // ranks above them.
    sal_mem #(
        .ADDR_W (SET_W),
        .DATA_W (ST_W)
    ) u_state_mem (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (rd_en),
        .rd_addr (in_set),
        .rd_data (st_rd_data)
    );

    sal_mem #(
        .ADDR_W (SET_W),
        .DATA_W (WAYS * TAG_W)
    ) u_tag_mem (
        .clk     (clk),
        .wr_en   (tag_wr_en),
        .wr_addr (set_reg),
        .wr_data (lk_tags),
        .rd_en   (rd_en),
        .rd_addr (in_set),
        .rd_data (tag_rd_data)
    );

    sal_lookup #(
        .WAYS   (WAYS),
        .TAG_W  (TAG_W),
        .RANK_W (RANK_W),
        .WAY_W  (WAY_W)
    ) u_lookup (
        .tags      (tag_rd_data),
        .valid     (st_rd_data[WAYS-1:0]),
        .ranks     (st_rd_data[ST_W-1:WAYS]),
        .req_line  (tag_reg),
        .hit       (lk_hit),
        .way       (lk_way),
        .valid_new (lk_valid),
        .ranks_new (lk_ranks),
        .tags_new  (lk_tags)
    );

    // After a clear, way i holds rank i.
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            init_ranks[w*RANK_W +: RANK_W] = RANK_W'(w);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        set_next      = set_reg;
        tag_next      = tag_reg;
        done_next     = 1'b0;
        hit_next      = hit_reg;
        way_next      = way_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        acc_cnt_next  = acc_cnt_reg;
        busy          = 1'b1;
        rd_en         = 1'b0;
        st_wr_en      = 1'b0;
        st_wr_addr    = set_reg;
        st_wr_data    = {lk_ranks, lk_valid};
        tag_wr_en     = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                st_wr_en     = 1'b1;
                st_wr_addr   = clr_idx_reg;
                st_wr_data   = {init_ranks, {WAYS{1'b0}}};
                clr_idx_next = clr_idx_reg + SET_W'(1);
                if (clr_idx_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (op == OP_CLEAR)
                    begin
                        done_next     = 1'b1;
                        hit_next      = 1'b0;
                        way_next      = '0;
                        hit_cnt_next  = '0;
                        miss_cnt_next = '0;
                        acc_cnt_next  = '0;
                        clr_idx_next  = '0;
                        state_next    = ST_CLEAR;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        set_next   = in_set;
                        tag_next   = in_line;
                        state_next = ST_LOOKUP;
                    end
                end
            end

            ST_LOOKUP:
            begin
                st_wr_en     = 1'b1;
                tag_wr_en    = !lk_hit;
                done_next    = 1'b1;
                hit_next     = lk_hit;
                way_next     = lk_way;
                acc_cnt_next = (acc_cnt_reg == CNT_MAX) ? CNT_MAX
                                                        : acc_cnt_reg + CNT_W'(1);
                if (lk_hit)
                begin
                    hit_cnt_next = (hit_cnt_reg == CNT_MAX) ? CNT_MAX
                                                            : hit_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    miss_cnt_next = (miss_cnt_reg == CNT_MAX) ? CNT_MAX
                                                              : miss_cnt_reg + CNT_W'(1);
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            done_reg     <= 1'b0;
            set_bits_reg <= SET_BITS_RESET;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            acc_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            done_reg     <= done_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            acc_cnt_reg  <= acc_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                set_bits_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg <= set_next;
        tag_reg <= tag_next;
        hit_reg <= hit_next;
        way_reg <= way_next;
    end

    logic [WAY_W+WAY_OUT_W-1:0] way_ext;

    assign way_ext      = (WAY_W + WAY_OUT_W)'(way_reg);
    assign cfg_ready    = 1'b1;
    assign done         = done_reg;
    assign hit          = hit_reg;
    assign way_used     = way_ext[WAY_OUT_W-1:0];
    assign hit_total    = hit_cnt_reg;
    assign miss_total   = miss_cnt_reg;
    assign access_total = acc_cnt_reg;

    // A result comes only from a lookup or from an accepted clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_LOOKUP)
                     || ($past(state_reg) == ST_IDLE && $past(start) && $past(op)))
        else $error("result strobe without a finished item");

    // Every access is either a hit or a miss until the access count saturates.
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc_cnt_reg == CNT_MAX)
        || ({1'b0, acc_cnt_reg} == ({1'b0, hit_cnt_reg} + {1'b0, miss_cnt_reg})))
        else $error("hit and miss counts do not add up to the access count");

    // No item is taken while the set-state memory is being swept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> busy)
        else $error("block not busy during clearing pass");

    // A clear result reports neither a hit nor any count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && state_reg == ST_CLEAR) |-> (!hit_reg && acc_cnt_reg == '0))
        else $error("clear result is not all zero");

endmodule

// ----- src/sal_mem.sv -----
`timescale 1ns / 1ps

module sal_mem #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [(1 << ADDR_W)];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/sal_lookup.sv -----
`timescale 1ns / 1ps

module sal_lookup #(
    parameter int WAYS   = 4,
    parameter int TAG_W  = 42,
    parameter int RANK_W = 2,
    parameter int WAY_W  = 2
) (
    input  logic [WAYS*TAG_W-1:0]  tags,
    input  logic [WAYS-1:0]        valid,
    input  logic [WAYS*RANK_W-1:0] ranks,
    input  logic [TAG_W-1:0]       req_line,
    output logic                   hit,
    output logic [WAY_W-1:0]       way,
    output logic [WAYS-1:0]        valid_new,
    output logic [WAYS*RANK_W-1:0] ranks_new,
    output logic [WAYS*TAG_W-1:0]  tags_new
);

    logic [WAY_W-1:0]  hit_way;
    logic              found;
    logic [WAY_W-1:0]  free_way;
    logic [WAY_W-1:0]  lru_way;
    logic [RANK_W:0]   best;
    logic [RANK_W-1:0] way_rank;
    logic [RANK_W-1:0] cur_rank;

    always_comb
    begin
        hit      = 1'b0;
        hit_way  = '0;
        found    = 1'b0;
        free_way = '0;
        lru_way  = '0;
        best     = '1;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit && valid[w] && (tags[w*TAG_W +: TAG_W] == req_line))
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!found && !valid[w])
            begin
                found    = 1'b1;
                free_way = WAY_W'(w);
            end
            if ({1'b0, ranks[w*RANK_W +: RANK_W]} < best)
            begin
                best    = {1'b0, ranks[w*RANK_W +: RANK_W]};
                lru_way = WAY_W'(w);
            end
        end

        if (hit)
        begin
            way = hit_way;
        end
        else if (found)
        begin
            way = free_way;
        end
        else
        begin
            way = lru_way;
        end

        // The chosen way becomes most recent; every way above it moves down one.
        way_rank  = ranks[way*RANK_W +: RANK_W];
        ranks_new = ranks;
        valid_new = valid;
        tags_new  = tags;
        for (int w = 0; w < WAYS; w++)
        begin
            cur_rank = ranks[w*RANK_W +: RANK_W];
            if (WAY_W'(w) == way)
            begin
                ranks_new[w*RANK_W +: RANK_W] = RANK_W'(WAYS - 1);
                valid_new[w]                  = 1'b1;
                if (!hit)
                begin
                    tags_new[w*TAG_W +: TAG_W] = req_line;
                end
            end
            else if (cur_rank > way_rank)
            begin
                ranks_new[w*RANK_W +: RANK_W] = cur_rank - RANK_W'(1);
            end
        end
    end

endmodule
